>>> hw/rtl/kdt_pkg.sv
// Package for the key directory table: table sizing, op codes, sequencer
// states and the slot record layout. No dependencies.
`default_nettype none

package kdt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int LIMIT_W     = 7;
  localparam int SPAN_W      = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int SLOT_W      = 6;
  localparam int OCC_W       = 7;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_FIND  = 2'd1,
    OP_LOAD  = 2'd2,
    OP_SCAN  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_WALK
  } state_t;

  // One stored slot: the key is what the walk compares, the rest rides along.
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] first_sector;
    logic [31:0] payload_bytes;
    logic [15:0] run_sectors;
    logic        pinned;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage

`default_nettype wire

>>> hw/rtl/kdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module kdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                          clk,
  input  wire logic                                          we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]                              wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output      logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/key_directory_table.sv
// Key directory table top level: command port, sequencer, slot walk.
// Depends on kdt_pkg and kdt_ram.
`default_nettype none
// Usage
//   Command channel: a command (op, key, run fields, seq) transfers on a rising
//   edge with start high and busy low; busy then stays high until it completes.
//   Ops: clear, find key, load (first free slot), scan-accept (insert unless
//   the key is already present).
//   Result channel: done pulses for one cycle with slot, hit, live_total,
//   upcoming_seq and occupancy valid in that cycle. The receiver cannot stall;
//   slot and hit mean something only with done, the totals hold until the next
//   command changes them.
//   Config channel: cfg_valid/cfg_ready/cfg_data writes slot_limit (slots
//   searched from slot 0 up, capped at the table depth). Write only while idle.
// Sequencing
//   Clear: the command moves the sequencer into its clear state, which registers done.
//   Find/load/scan: one walk step per slot through the shared key RAM read
//   port and comparator, plus one step for the registered read. Find and
//   load stop at the first hit or free slot; scan stops at a duplicate key
//   and otherwise walks the whole span.
//   A new command can transfer in the done cycle.
// Reset
//   Synchronous rst empties the table (valid bits only), zeroes totals, sets
//   slot_limit to 64. Key/run storage is not cleared; it is gated by the bits.

module key_directory_table (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // command
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic [1:0]                    op,
  input  wire logic [31:0]                   key,
  input  wire logic [31:0]                   first_sector,
  input  wire logic [15:0]                   run_sectors,
  input  wire logic [31:0]                   payload_bytes,
  input  wire logic                          pinned,
  input  wire logic [31:0]                   seq,
  // result
  output      logic                          done,
  output      logic [kdt_pkg::SLOT_W-1:0]    slot,
  output      logic                          hit,
  output      logic [31:0]                   live_total,
  output      logic [31:0]                   upcoming_seq,
  output      logic [kdt_pkg::OCC_W-1:0]     occupancy,
  // config
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [kdt_pkg::LIMIT_W-1:0]   cfg_data
);

  kdt_pkg::state_t state, state_next;

  // latched command
  kdt_pkg::op_t op_q;
  kdt_pkg::rec_t rec_q;
  logic [31:0] seq_q;

  // table state
  logic [kdt_pkg::TABLE_DEPTH-1:0] used;
  logic [kdt_pkg::CNT_W-1:0]       used_count;
  logic [31:0]                     live_sum;
  logic [31:0]                     highest_seq;
  logic [kdt_pkg::LIMIT_W-1:0]     slot_limit;

  // walk state
  logic [kdt_pkg::CNT_W-1:0] idx;
  logic                      pend;
  logic [kdt_pkg::IDX_W-1:0] pend_idx;
  logic                      free_ok;
  logic [kdt_pkg::IDX_W-1:0] free_idx;

  logic [kdt_pkg::REC_W-1:0] rd_data;
  kdt_pkg::rec_t             rd_rec;

  logic [kdt_pkg::SPAN_W-1:0] limit_ext;
  logic [kdt_pkg::CNT_W-1:0]  span;
  logic                       issue, walk_end;
  logic                       cmp_used, cmp_match, cmp_free, have_free;
  logic [kdt_pkg::IDX_W-1:0]  first_free;

  // actions from the output decode
  logic                      fin, fin_hit, ins_en, add_len, raise_seq, clear_all;
  logic [kdt_pkg::IDX_W-1:0] fin_idx;

  // span = min(slot_limit, depth)
  always_comb begin
    limit_ext = kdt_pkg::SPAN_W'(slot_limit);
    if (limit_ext > kdt_pkg::SPAN_W'(kdt_pkg::TABLE_DEPTH)) begin
      span = kdt_pkg::CNT_W'(kdt_pkg::TABLE_DEPTH);
    end else begin
      span = limit_ext[kdt_pkg::CNT_W-1:0];
    end
  end

  assign rd_rec     = kdt_pkg::rec_t'(rd_data);
  assign issue      = (idx < span);
  assign walk_end   = !issue;
  assign cmp_used   = used[pend_idx];
  assign cmp_match  = pend && cmp_used && (rd_rec.key == rec_q.key);
  assign cmp_free   = pend && !cmp_used;
  assign have_free  = free_ok || cmp_free;
  assign first_free = free_ok ? free_idx : pend_idx;

  // key RAM, one slot read per walk step
  kdt_ram #(
    .WIDTH (kdt_pkg::REC_W),
    .DEPTH (kdt_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ins_en),
    .waddr (fin_idx),
    .wdata (rec_q),
    .raddr (idx[kdt_pkg::IDX_W-1:0]),
    .rdata (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      kdt_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (kdt_pkg::op_t'(op) == kdt_pkg::OP_CLEAR) ?
                       kdt_pkg::ST_CLEAR : kdt_pkg::ST_WALK;
        end
      end
      kdt_pkg::ST_CLEAR: state_next = kdt_pkg::ST_IDLE;
      kdt_pkg::ST_WALK: begin
        if (fin) begin
          state_next = kdt_pkg::ST_IDLE;
        end
      end
      default: state_next = kdt_pkg::ST_IDLE;
    endcase
  end

  // action decode
  always_comb begin
    fin       = 1'b0;
    fin_hit   = 1'b0;
    fin_idx   = '0;
    ins_en    = 1'b0;
    add_len   = 1'b0;
    raise_seq = 1'b0;
    clear_all = 1'b0;
    unique case (state)
      kdt_pkg::ST_IDLE: ;
      kdt_pkg::ST_CLEAR: begin
        fin       = 1'b1;
        clear_all = 1'b1;
      end
      kdt_pkg::ST_WALK: begin
        unique case (op_q)
          kdt_pkg::OP_FIND: begin
            if (cmp_match) begin
              fin     = 1'b1;
              fin_hit = 1'b1;
              fin_idx = pend_idx;
            end else if (walk_end) begin
              fin = 1'b1;
            end
          end
          kdt_pkg::OP_LOAD: begin
            // live total grows whether or not the insert lands
            if (cmp_free) begin
              fin     = 1'b1;
              fin_hit = 1'b1;
              fin_idx = pend_idx;
              ins_en  = 1'b1;
              add_len = 1'b1;
            end else if (walk_end) begin
              fin     = 1'b1;
              add_len = 1'b1;
            end
          end
          kdt_pkg::OP_SCAN: begin
            // duplicate check needs the whole span before inserting
            if (cmp_match) begin
              fin = 1'b1;
            end else if (walk_end) begin
              fin = 1'b1;
              if (have_free) begin
                fin_hit   = 1'b1;
                fin_idx   = first_free;
                ins_en    = 1'b1;
                add_len   = 1'b1;
                raise_seq = 1'b1;
              end
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= kdt_pkg::ST_IDLE;
      used        <= '0;
      used_count  <= '0;
      live_sum    <= '0;
      highest_seq <= '0;
      slot_limit  <= kdt_pkg::LIMIT_RESET;
      done        <= 1'b0;
      idx         <= '0;
      pend        <= 1'b0;
      free_ok     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
      if (cfg_valid && cfg_ready) begin
        slot_limit <= cfg_data;
      end
      if (state == kdt_pkg::ST_IDLE) begin
        idx     <= '0;
        pend    <= 1'b0;
        free_ok <= 1'b0;
      end else if (state == kdt_pkg::ST_WALK) begin
        pend <= issue;
        if (issue) begin
          idx <= idx + 1'b1;
        end
        if (cmp_free && !free_ok) begin
          free_ok <= 1'b1;
        end
      end
      if (clear_all) begin
        used        <= '0;
        used_count  <= '0;
        live_sum    <= '0;
        highest_seq <= '0;
      end
      if (ins_en) begin
        used[fin_idx] <= 1'b1;
        used_count    <= used_count + 1'b1;
      end
      if (add_len) begin
        live_sum <= live_sum + 32'(rec_q.run_sectors);
      end
      if (raise_seq && (seq_q > highest_seq)) begin
        highest_seq <= seq_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_q                <= kdt_pkg::op_t'(op);
      rec_q.key           <= key;
      rec_q.first_sector  <= first_sector;
      rec_q.payload_bytes <= payload_bytes;
      rec_q.run_sectors   <= run_sectors;
      rec_q.pinned        <= pinned;
      seq_q               <= seq;
    end
    pend_idx <= idx[kdt_pkg::IDX_W-1:0];
    if (state == kdt_pkg::ST_WALK && cmp_free && !free_ok) begin
      free_idx <= pend_idx;
    end
    if (fin) begin
      hit  <= fin_hit;
      slot <= kdt_pkg::SLOT_W'(fin_idx);
    end
  end

  assign busy         = (state != kdt_pkg::ST_IDLE);
  assign cfg_ready    = 1'b1;
  assign live_total   = live_sum;
  assign upcoming_seq = highest_seq + 32'd1;
  assign occupancy    = kdt_pkg::OCC_W'(used_count);

  // checks
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state != kdt_pkg::ST_IDLE))
    else $error("done without a command in progress");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(used) == int'(used_count))
    else $error("occupancy count out of step with valid bits");

  a_miss_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (slot == '0))
    else $error("miss reported a nonzero slot");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command transfer did not raise busy");

endmodule

`default_nettype wire

>>> sim/kdt_checker.sv
`timescale 1ns / 100ps
// Checker for key_directory_table: keeps its own copy of the slot table,
// predicts each result from the command and config transfers it sees and
// compares. Depends on kdt_pkg.

module kdt_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic [1:0]                           op,
  input  logic [31:0]                          key,
  input  logic [15:0]                          run_sectors,
  input  logic [31:0]                          seq,
  input  logic                                 done,
  input  logic [kdt_pkg::SLOT_W-1:0]           slot,
  input  logic                                 hit,
  input  logic [31:0]                          live_total,
  input  logic [31:0]                          upcoming_seq,
  input  logic [kdt_pkg::OCC_W-1:0]            occupancy,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [kdt_pkg::LIMIT_W-1:0]          cfg_data,
  output int                                   errors,
  output int                                   outstanding,
  output int                                   results_seen,
  output int                                   hits_seen
);

  typedef struct packed {
    logic [kdt_pkg::SLOT_W-1:0] slot;
    logic                       hit;
    logic [31:0]                live;
    logic [31:0]                nseq;
    logic [kdt_pkg::OCC_W-1:0]  occ;
  } dir_result_t;

  // shadow table: only keys and valid bits are observable at the outputs
  logic                        slot_live [kdt_pkg::TABLE_DEPTH];
  logic [31:0]                 slot_key  [kdt_pkg::TABLE_DEPTH];
  logic [31:0]                 live_sum;
  logic [31:0]                 top_seq;
  logic [kdt_pkg::OCC_W-1:0]   used_n;
  logic [kdt_pkg::LIMIT_W-1:0] limit_q;

  dir_result_t due_results [$];

  function automatic int search_span();
    return (limit_q > kdt_pkg::TABLE_DEPTH) ? kdt_pkg::TABLE_DEPTH : int'(limit_q);
  endfunction

  function automatic bit find_key(input logic [31:0] k, output int at);
    at = 0;
    for (int i = 0; i < search_span(); i++) begin
      if (slot_live[i] && slot_key[i] == k) begin
        at = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit take_free(input logic [31:0] k, output int at);
    at = 0;
    for (int i = 0; i < search_span(); i++) begin
      if (!slot_live[i]) begin
        slot_live[i] = 1'b1;
        slot_key[i]  = k;
        used_n       = used_n + 1'b1;
        at           = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Apply one command to the shadow table and return what the block must report.
  function automatic dir_result_t dir_step(input kdt_pkg::op_t c, input logic [31:0] k,
                                           input logic [15:0] cnt, input logic [31:0] sq);
    dir_result_t r;
    int          at;
    int          dup_at;
    bit          got;
    at  = 0;
    got = 1'b0;
    case (c)
      kdt_pkg::OP_CLEAR: begin
        for (int i = 0; i < kdt_pkg::TABLE_DEPTH; i++) slot_live[i] = 1'b0;
        used_n   = '0;
        live_sum = '0;
        top_seq  = '0;
      end
      kdt_pkg::OP_FIND: got = find_key(k, at);
      kdt_pkg::OP_LOAD: begin
        got      = take_free(k, at);
        live_sum = live_sum + 32'(cnt);   // grows even when the table is full
      end
      default: begin
        if (!find_key(k, dup_at)) begin
          got = take_free(k, at);
          if (got) begin
            live_sum = live_sum + 32'(cnt);
            if (sq > top_seq) top_seq = sq;
          end
        end
      end
    endcase
    r.slot = got ? at[kdt_pkg::SLOT_W-1:0] : '0;
    r.hit  = got;
    r.live = live_sum;
    r.nseq = top_seq + 32'd1;
    r.occ  = used_n;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    dir_result_t e;
    if (rst) begin
      for (int i = 0; i < kdt_pkg::TABLE_DEPTH; i++) slot_live[i] = 1'b0;
      live_sum = '0;
      top_seq  = '0;
      used_n   = '0;
      limit_q  = kdt_pkg::LIMIT_RESET;
      due_results.delete();
      outstanding <= 0;
    end else begin
      // a result retires before a command taken on the same edge is queued
      if (done) begin
        results_seen++;
        if (hit) hits_seen++;
        if (due_results.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          e = due_results.pop_front();
          check_field("slot", e.slot, slot);
          check_field("hit", e.hit, hit);
          check_field("live_total", e.live, live_total);
          check_field("upcoming_seq", e.nseq, upcoming_seq);
          check_field("occupancy", e.occ, occupancy);
        end
      end
      if (start && !busy)
        due_results.push_back(dir_step(kdt_pkg::op_t'(op), key, run_sectors, seq));
      if (cfg_valid && cfg_ready) limit_q = cfg_data;
      outstanding <= due_results.size();
    end
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// Top of the key_directory_table testbench: clock, reset, command and
// slot_limit stimulus, verdict. Depends on kdt_pkg, key_directory_table
// and kdt_checker.

module tb;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         start;
  logic                         busy;
  logic [1:0]                   op;
  logic [31:0]                  key;
  logic [31:0]                  first_sector;
  logic [15:0]                  run_sectors;
  logic [31:0]                  payload_bytes;
  logic                         pinned;
  logic [31:0]                  seq;
  logic                         done;
  logic [kdt_pkg::SLOT_W-1:0]   slot;
  logic                         hit;
  logic [31:0]                  live_total;
  logic [31:0]                  upcoming_seq;
  logic [kdt_pkg::OCC_W-1:0]    occupancy;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [kdt_pkg::LIMIT_W-1:0]  cfg_data;

  int errors;
  int outstanding;
  int results_seen;
  int hits_seen;

  // sender bookkeeping
  int burst_left;
  int cmds_sent;
  int limit_writes;

  // small key pool per phase so finds hit and scans see duplicates
  logic [31:0] key_pool [16];

  // random phases: slot_limit (-1 picks one at random), command count, clear rate in %
  int phase_limit [8] = '{64, 1, 0, 127, 16, 65, -1, 64};
  int phase_items [8] = '{240, 150, 100, 260, 200, 200, 300, 300};
  int phase_clear [8] = '{1, 3, 2, 0, 1, 3, 2, 1};

  key_directory_table u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .key           (key),
    .first_sector  (first_sector),
    .run_sectors   (run_sectors),
    .payload_bytes (payload_bytes),
    .pinned        (pinned),
    .seq           (seq),
    .done          (done),
    .slot          (slot),
    .hit           (hit),
    .live_total    (live_total),
    .upcoming_seq  (upcoming_seq),
    .occupancy     (occupancy),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  kdt_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .key          (key),
    .run_sectors  (run_sectors),
    .seq          (seq),
    .done         (done),
    .slot         (slot),
    .hit          (hit),
    .live_total   (live_total),
    .upcoming_seq (upcoming_seq),
    .occupancy    (occupancy),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .hits_seen    (hits_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop, set well beyond the slowest legal run (full walks plus the
  // longest gaps between commands).
  initial begin
    #15_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // One command transfer. start stays high across a burst so back-to-back
  // commands land in the done cycle; between bursts the line goes quiet for
  // a random gap, short mostly, sometimes longer than a full 64-slot walk.
  task automatic send_cmd(input kdt_pkg::op_t c, input logic [31:0] k,
                          input logic [31:0] ss, input logic [15:0] cnt,
                          input logic [31:0] bl, input logic pin, input logic [31:0] sq);
    start         <= 1'b1;
    op            <= c;
    key           <= k;
    first_sector  <= ss;
    run_sectors   <= cnt;
    payload_bytes <= bl;
    pinned        <= pin;
    seq           <= sq;
    do @(posedge clk); while (busy);
    cmds_sent++;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 6))
        @(posedge clk);
      // now and then a long stretch with no idling at all
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  // Stop sending and wait until every result is back. The wait starts with a
  // clock edge so the checker's count covers the last transfer.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [kdt_pkg::LIMIT_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_writes++;
  endtask

  task automatic random_cmd(input int clear_pct);
    int           r;
    kdt_pkg::op_t c;
    logic [31:0]  k;
    logic [31:0]  sq;
    r = $urandom_range(0, 99);
    if (r < clear_pct)  c = kdt_pkg::OP_CLEAR;
    else if (r < 35)    c = kdt_pkg::OP_FIND;
    else if (r < 62)    c = kdt_pkg::OP_LOAD;
    else                c = kdt_pkg::OP_SCAN;
    k = ($urandom_range(0, 6) == 0) ? $urandom : key_pool[$urandom_range(0, 15)];
    case ($urandom_range(0, 3))
      0:       sq = $urandom_range(0, 255);
      1:       sq = 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: sq = $urandom;
    endcase
    send_cmd(c, k, $urandom, 16'($urandom_range(0, 65535)), $urandom,
             1'($urandom_range(0, 1)), sq);
  endtask

  initial begin
    int lim;
    rst           = 1'b1;
    start         = 1'b0;
    op            = kdt_pkg::OP_CLEAR;
    key           = '0;
    first_sector  = '0;
    run_sectors   = '0;
    payload_bytes = '0;
    pinned        = 1'b0;
    seq           = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    burst_left    = 0;
    cmds_sent     = 0;
    limit_writes  = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed: reset limit of 64 ---
    send_cmd(kdt_pkg::OP_FIND, 32'h0, '0, '0, '0, 1'b0, '0);           // empty table miss
    send_cmd(kdt_pkg::OP_SCAN, '1, '1, 16'hFFFF, '1, 1'b1, '1);        // all ones; seq wraps to 0
    send_cmd(kdt_pkg::OP_SCAN, '1, '0, 16'h0001, '0, 1'b0, 32'd5);     // duplicate skipped
    send_cmd(kdt_pkg::OP_LOAD, 32'h0, '0, 16'h0000, '0, 1'b0, '0);     // all zero fields
    send_cmd(kdt_pkg::OP_LOAD, 32'h0, 32'h5555_AAAA, 16'h00FF, 32'hAAAA_5555, 1'b1,
             '1);                                                      // load skips dup check
    send_cmd(kdt_pkg::OP_FIND, 32'h0, '0, '0, '0, 1'b0, '0);           // lowest holder of key 0
    send_cmd(kdt_pkg::OP_FIND, '1, '0, '0, '0, 1'b0, '0);
    send_cmd(kdt_pkg::OP_SCAN, 32'h7, 32'h1, 16'h8000, 32'h1, 1'b0, 32'd3); // lower seq keeps top
    send_cmd(kdt_pkg::OP_CLEAR, '1, '1, 16'hFFFF, '1, 1'b1, '1);
    send_cmd(kdt_pkg::OP_FIND, '1, '0, '0, '0, 1'b0, '0);              // gone after clear
    send_cmd(kdt_pkg::OP_SCAN, 32'h7, '0, 16'h0010, '0, 1'b0, 32'd3);

    // span zero: nothing searched, load still adds to the total
    write_limit(7'd0);
    send_cmd(kdt_pkg::OP_LOAD, 32'h9, '0, 16'hFFFF, '0, 1'b1, '0);
    send_cmd(kdt_pkg::OP_SCAN, 32'h9, '0, 16'h0100, '0, 1'b0, 32'd100);
    send_cmd(kdt_pkg::OP_FIND, 32'h7, '0, '0, '0, 1'b0, '0);
    // span one: slot 0 is taken, so inserts see a full table
    write_limit(7'd1);
    send_cmd(kdt_pkg::OP_FIND, 32'h7, '0, '0, '0, 1'b0, '0);
    send_cmd(kdt_pkg::OP_LOAD, 32'h9, '0, 16'h0002, '0, 1'b0, '0);
    send_cmd(kdt_pkg::OP_SCAN, 32'hA, '0, 16'h0002, '0, 1'b0, 32'd50);
    // limit above depth searches the whole table
    write_limit(7'd127);
    send_cmd(kdt_pkg::OP_LOAD, 32'h9, '0, 16'h0003, '0, 1'b0, '0);
    send_cmd(kdt_pkg::OP_SCAN, 32'hA, '0, 16'h0004, '0, 1'b1, 32'd50);
    send_cmd(kdt_pkg::OP_FIND, 32'hA, '0, '0, '0, 1'b0, '0);

    // --- random phases, each at its own slot_limit; the table carries over,
    // so a lowered limit leaves in-use slots above it ---
    for (int p = 0; p < 8; p++) begin
      lim = (phase_limit[p] < 0) ? $urandom_range(2, 63) : phase_limit[p];
      write_limit(lim[kdt_pkg::LIMIT_W-1:0]);
      foreach (key_pool[i]) key_pool[i] = $urandom;
      key_pool[0] = 32'h0;
      key_pool[1] = '1;
      for (int n = 0; n < phase_items[p]; n++) begin
        random_cmd(phase_clear[p]);
        if ($urandom_range(0, 99) == 0) drain();   // hold off until the pipe is empty
      end
    end

    // --- wind down: wait out the last results, then a walk's worth of cycles ---
    start <= 1'b0;
    @(posedge clk);
    for (int w = 0; w < 2000 && outstanding != 0; w++) @(posedge clk);
    repeat (70) @(posedge clk);

    $display("summary: %0d commands, %0d results (%0d hits), %0d slot_limit writes",
             cmds_sent, results_seen, hits_seen, limit_writes);
    $display("summary: limits 0, 1, 16, 64, 65, 127 and random; full and lowered-limit tables");
    if (errors == 0 && outstanding == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
